// ===== sv/mie_pkg.sv =====
package mie_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef logic [WIDTH-1:0] word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_ISSUE,
    S_DIVIDE,
    S_OUT
  } state_t;

  // Command to the shared divide and accumulate unit.
  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
    word_t mult;
  } div_cmd_t;

  // Status returned by that unit; rem and acc are meaningful while done is high.
  typedef struct packed {
    logic  done;
    word_t rem;
    word_t acc;
  } div_rsp_t;

endpackage

// ===== sv/mie_divider.sv =====
module mie_divider (
  input  logic              clk,
  input  logic              rst,
  input  mie_pkg::div_cmd_t cmd,
  output mie_pkg::div_rsp_t rsp
);
  import mie_pkg::*;

  logic              busy;
  logic [CNT_W-1:0]  count;
  word_t             rem;
  word_t             dvd;
  word_t             divisor;
  word_t             mult;
  word_t             acc;
  logic              done;

  logic [WIDTH:0]    trial;
  logic              ge;
  word_t             rem_next;
  word_t             acc_next;

  // One quotient bit per cycle, most significant first. Each quotient bit also
  // folds the multiplier into acc, so acc ends as quotient times mult.
  always_comb begin
    trial    = {rem, dvd[WIDTH-1]};
    ge       = (trial >= {1'b0, divisor});
    rem_next = ge ? WIDTH'(trial - {1'b0, divisor}) : trial[WIDTH-1:0];
    acc_next = WIDTH'({acc, 1'b0}) + (ge ? mult : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy && (count == CNT_W'(1));
      if (cmd.start) begin
        busy  <= 1'b1;
        count <= CNT_W'(WIDTH);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem     <= '0;
      dvd     <= cmd.dividend;
      divisor <= cmd.divisor;
      mult    <= cmd.mult;
      acc     <= '0;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[WIDTH-2:0], 1'b0};
      acc <= acc_next;
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;
  assign rsp.acc  = acc;

endmodule

// ===== sv/modular_inverse_ext_euclid.sv =====
// Modular inverse by the extended Euclidean algorithm.
// Input channel: value and modulus, taken when in_valid is high and in_stall
// is low. in_stall stays high from the accepted transaction until its result
// has been taken, so one item is in flight at a time.
// Output channel: inverse, exists and common_divisor, offered with out_valid
// and held unchanged for as long as out_stall is high.
// Operation: the value is first reduced modulo the modulus, then one remainder
// step is done per Euclid iteration. Every step uses the one shared
// shift-subtract divider, which builds quotient times coefficient as it goes.
// A value that reduces to zero finishes after the reduction alone, and a
// modulus of zero is offered at the output on the next cycle.
// The next transaction can be taken once the result has gone and the block
// is back in its idle state; it takes no new item before then.
// Reset clears the sequencer and the divider; any item in flight is dropped
// and the block comes back ready for a new transaction.
// A stalled receiver simply holds the block in its output state; no new
// transaction is taken until the result has gone.
module modular_inverse_ext_euclid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          value,
  input  logic [31:0]          modulus,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          inverse,
  output logic                 exists,
  output logic [31:0]          common_divisor
);
  import mie_pkg::*;

  state_t   state, state_next;
  div_cmd_t cmd;
  div_rsp_t rsp;

  word_t m, r0, r1, u0, u1;
  logic  n1;
  word_t inv_r, g_r;
  logic  ok_r;
  word_t un;

  logic  in_acc;
  logic  out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign un      = u0 + rsp.acc;

  mie_divider u_div (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.start    = 1'b0;
    cmd.dividend = word_t'(value);
    cmd.divisor  = word_t'(modulus);
    cmd.mult     = '0;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (modulus == '0) begin
            state_next = S_OUT;
          end else begin
            cmd.start  = 1'b1;
            state_next = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (rsp.done) begin
          state_next = (rsp.rem == '0) ? S_OUT : S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.start    = 1'b1;
        cmd.dividend = r0;
        cmd.divisor  = r1;
        cmd.mult     = u1;
        state_next   = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (rsp.done) begin
          state_next = (rsp.rem == '0) ? S_OUT : S_ISSUE;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          m     <= word_t'(modulus);
          inv_r <= '0;
          ok_r  <= 1'b0;
          g_r   <= word_t'(value);
        end
      end
      S_REDUCE: begin
        if (rsp.done) begin
          r0 <= m;
          r1 <= rsp.rem;
          u0 <= '0;
          u1 <= word_t'(1);
          n1 <= 1'b0;
          g_r  <= m;
          ok_r <= (m == word_t'(1));
        end
      end
      S_DIVIDE: begin
        if (rsp.done) begin
          r0 <= r1;
          r1 <= rsp.rem;
          u0 <= u1;
          u1 <= un;
          n1 <= !n1;
          if (rsp.rem == '0) begin
            // The previous remainder is the gcd and u1 its coefficient.
            g_r  <= r1;
            ok_r <= (r1 == word_t'(1));
            if (r1 == word_t'(1)) begin
              inv_r <= (n1 && u1 != '0) ? (m - u1) : u1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign in_stall       = (state != S_IDLE);
  assign out_valid      = (state == S_OUT);
  assign inverse        = 32'(inv_r);
  assign exists         = ok_r;
  assign common_divisor = 32'(g_r);

  a_exists_gcd_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && exists |-> common_divisor == 32'd1)
    else $error("exists reported with a gcd other than one");

  a_inverse_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && exists && (m != word_t'(1)) |-> inv_r < m)
    else $error("inverse not reduced below the modulus");

  a_no_inverse_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !exists |-> inverse == 32'd0)
    else $error("inverse nonzero although none exists");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == S_REDUCE || state == S_DIVIDE))
    else $error("divider finished outside a waiting state");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("block ready again straight after taking a transaction");

endmodule

// ===== tb/sv/tb_modular_inverse_ext_euclid.sv =====
module tb_modular_inverse_ext_euclid;
  import mie_pkg::*;

  typedef struct packed {
    word_t inverse;
    logic  exists;
    word_t common_divisor;
  } inv_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] value = '0;
  logic [31:0] modulus = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] inverse;
  logic        exists;
  logic [31:0] common_divisor;

  inv_result_t pending_results[$];
  int          mismatches = 0;
  int          failures = 0;
  int          n_sent = 0;
  int          n_received = 0;
  int          n_invertible = 0;
  int          n_shared = 0;
  int          stall_left = 0;
  bit          no_gaps = 1'b0;

  modular_inverse_ext_euclid dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .value(value), .modulus(modulus),
    .out_valid(out_valid), .out_stall(out_stall),
    .inverse(inverse), .exists(exists), .common_divisor(common_divisor)
  );

  always #6 clk = ~clk;

  // Bezout coefficient of the value is tracked as a magnitude and a sign,
  // since the signs alternate from one remainder step to the next.
  function automatic inv_result_t predict_inverse(word_t v, word_t m);
    logic [63:0] r0, r1, q, r, u0, u1, un, inv;
    logic n0, n1;
    inv_result_t res;
    res = '0;
    if (m == '0) begin
      res.common_divisor = v;
    end else begin
      r0 = 64'(m);
      r1 = 64'(v % m);
      if (r1 == 0) begin
        res.common_divisor = m;
        res.exists = (m == word_t'(1));
      end else begin
        u0 = 0;
        u1 = 1;
        n0 = 1'b0;
        n1 = 1'b0;
        while (r1 != 0) begin
          q = r0 / r1;
          r = r0 - q * r1;
          un = u0 + q * u1;
          r0 = r1;
          r1 = r;
          u0 = u1;
          n0 = n1;
          u1 = un;
          n1 = ~n1;
        end
        res.common_divisor = word_t'(r0);
        if (r0 == 1) begin
          res.exists = 1'b1;
          inv = (n0 && u0 != 0) ? (64'(m) - u0) : u0;
          inv = inv % 64'(m);
          res.inverse = word_t'(inv);
        end
      end
    end
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 200);
  endfunction

  function automatic word_t rand_modulus();
    word_t m;
    m = $urandom;
    if (m == '0) m = 1;
    return m;
  endfunction

  // Offers one transaction and returns at the edge where it is taken;
  // in_valid is left high so the next item can follow without a bubble.
  task automatic send_item(word_t v, word_t m);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    modulus <= m;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_inverse(v, m));
    n_sent++;
  endtask

  always @(posedge clk) begin
    inv_result_t exp_res;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_received++;
        if (pending_results.size() == 0) begin
          failures++;
          $display("unexpected result: inverse=%0d exists=%0b gcd=%0d",
                   inverse, exists, common_divisor);
        end else begin
          exp_res = pending_results.pop_front();
          if (exp_res.exists) n_invertible++;
          if (exp_res.common_divisor != word_t'(1)) n_shared++;
          if (inverse !== exp_res.inverse || exists !== exp_res.exists ||
              common_divisor !== exp_res.common_divisor) begin
            mismatches++;
            failures++;
            if (mismatches <= 10)
              $display("mismatch %0d: exp inv=%0d ex=%0b gcd=%0d, got inv=%0d ex=%0b gcd=%0d",
                       n_received, exp_res.inverse, exp_res.exists,
                       exp_res.common_divisor, inverse, exists, common_divisor);
          end
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= pick_gap();
      end
    end
  end

  task automatic test_directed();
    send_item(32'd0, 32'd1);
    send_item(32'd1, 32'd1);
    send_item(32'hFFFF_FFFF, 32'd1);
    send_item(32'd0, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_item(32'h8000_0000, 32'hFFFF_FFFF);
    send_item(32'd1, 32'h8000_0000);
    send_item(32'd3, 32'd7);
    send_item(32'd10, 32'd7);
    send_item(32'd1, 32'd2);
    send_item(32'd2, 32'd4);
    send_item(32'd12, 32'd18);
    send_item(32'd35, 32'd7);
    send_item(32'd1836311903, 32'd2971215073);
    send_item(32'd2971215073, 32'd1836311903);
    send_item(32'hFFFF_FFFF, 32'd2);
  endtask

  task automatic test_random_pairs(int count);
    repeat (count) send_item($urandom, rand_modulus());
  endtask

  // Small moduli force a large reduction step and give many trivial cases.
  task automatic test_small_moduli(int count);
    repeat (count) send_item($urandom, $urandom_range(1, 300));
  endtask

  task automatic test_shared_factor(int count);
    word_t d, a, b;
    repeat (count) begin
      d = $urandom_range(2, 65536);
      a = $urandom_range(0, 32'hFFFF_FFFF / d);
      b = $urandom_range(1, 32'hFFFF_FFFF / d);
      send_item(a * d, b * d);
    end
  endtask

  // Consecutive Fibonacci numbers give the longest remainder chains.
  task automatic test_long_chains(int count);
    logic [63:0] fa, fb, ft;
    int idx;
    repeat (count) begin
      idx = $urandom_range(25, 45);
      fa = 1;
      fb = 1;
      repeat (idx) begin
        ft = fa + fb;
        fa = fb;
        fb = ft;
      end
      if ($urandom_range(0, 1))
        send_item(word_t'(fa), word_t'(fb));
      else
        send_item(word_t'(fa + $urandom_range(0, 3)), word_t'(fb));
    end
  endtask

  task automatic test_back_to_back(int count);
    no_gaps = 1'b1;
    test_random_pairs(count);
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_pairs(150);
    test_small_moduli(60);
    test_shared_factor(60);
    test_long_chains(20);
    test_back_to_back(60);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d transactions, checked %0d results.", n_sent, n_received);
    $display("Of those, %0d had an inverse and %0d had a common divisor above one.",
             n_invertible, n_shared);
    if (failures == 0 && pending_results.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #48_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
